// File: rtl/core/bmsa_pkg.sv
`default_nettype none
package bmsa_pkg;

	// Geometry
	localparam int DIM_MAX     = 16;
	localparam int DIM_W       = $clog2(DIM_MAX);
	localparam int DIMS_W      = 5;
	localparam int SAMPLE_BITS = 16;
	localparam int BATCH_W     = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Result field widths
	localparam int MEAN_W   = 32;
	localparam int STDERR_W = 32;
	localparam int VAR_W    = 48;
	localparam int COUNT_W  = 32;

	// Accumulator widths
	localparam int PSUM_W = 40;
	localparam int BSUM_W = 48;
	localparam int WIDE_W = 64;

	// Iteration counts of the shared units
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int MUL_STEPS  = 3;
	localparam int OPCNT_W    = 7;

	// Register reset values
	localparam logic [BATCH_W-1:0] BATCH_SIZE_RST = 16'd1024;
	localparam logic [DIMS_W-1:0]  DIMS_RST       = 5'd16;
	localparam logic               MODE_RST       = 1'b0;

	// Item kinds and modes
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_REPORT = 1'b1;
	localparam logic MODE_BATCH  = 1'b0;
	localparam logic MODE_SIMPLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BATCH_SIZE  = 2'd0,
		CFG_DIMS_IN_USE = 2'd1,
		CFG_STAT_MODE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RPT_OK      = 2'd0,
		RPT_NO_DATA = 2'd1,
		RPT_FEW     = 2'd2
	} rpt_status_t;

	typedef enum logic [1:0] {
		OP_DIV  = 2'd0,
		OP_SQRT = 2'd1,
		OP_MUL  = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WAIT,
		ST_SAMP_UPD,
		ST_CB_DIVM,
		ST_CB_MEAN,
		ST_CB_DIVQ,
		ST_CB_VAR,
		ST_CB_FOLD,
		ST_RB_MEAN,
		ST_RB_DIVA,
		ST_RB_DIVV,
		ST_RB_MV,
		ST_RB_SQM,
		ST_RB_MUL,
		ST_RB_DIVW,
		ST_RB_DIVX,
		ST_RB_SQV,
		ST_RB_END,
		ST_RS_MEAN,
		ST_RS_DIVA,
		ST_RS_S,
		ST_RS_SQ,
		ST_RS_END,
		ST_REP_OUT
	} state_t;

endpackage
`default_nettype wire

// File: rtl/core/bmsa_cfg_if.sv
`default_nettype none
interface bmsa_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [bmsa_pkg::CFG_IDX_W-1:0]      index;
	logic [bmsa_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bmsa_in_if.sv
`default_nettype none
interface bmsa_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   kind;
	logic [bmsa_pkg::DIM_W-1:0]             dim_index;
	logic signed [bmsa_pkg::SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, kind, dim_index, sample_value, input ready);
	modport sink (input valid, kind, dim_index, sample_value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bmsa_out_if.sv
`default_nettype none
interface bmsa_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [bmsa_pkg::MEAN_W-1:0]   mean_value;
	logic [bmsa_pkg::STDERR_W-1:0]        mean_stderr;
	logic [bmsa_pkg::VAR_W-1:0]           mean_variance;
	logic [bmsa_pkg::VAR_W-1:0]           variance_stderr;
	logic [bmsa_pkg::COUNT_W-1:0]         sample_count;
	logic [1:0]                           report_status;
	logic [bmsa_pkg::DIM_W-1:0]           report_dim;

	modport source (output valid, mean_value, mean_stderr, mean_variance, variance_stderr,
		sample_count, report_status, report_dim, input ready);
	modport sink (input valid, mean_value, mean_stderr, mean_variance, variance_stderr,
		sample_count, report_status, report_dim, output ready);
endinterface
`default_nettype wire

// File: rtl/core/batch_means_statistics_accumulator_unit.sv
`default_nettype none
// Batch-means statistics accumulator for Monte Carlo paths. Sample elements
// arrive one dimension at a time; each updates that dimension's running sum
// and sum of squares. The element of the last dimension in use completes a
// path, and in batched mode the path that fills a batch folds every dimension
// in use into the cross-batch sums. A report request is worked out in simple
// or batched mode, or answered without arithmetic when there is no data or
// its dimension is not in use. All of this work is done by one shared
// one-bit-per-cycle divider, a two-bit-per-cycle square root and a 48x16
// multiplier, all run by one sequencer; the block takes no item while it
// works. A finished report waits in an output register and the next item
// is taken meanwhile. Configuration writes are taken at any time and must
// only be made while the block is idle.
module batch_means_statistics_accumulator_unit (
	input  wire          clk,
	input  wire          arst_n,
	bmsa_cfg_if.sink     cfg,
	bmsa_in_if.sink      samples,
	bmsa_out_if.source   reports
);

	// Configuration
	logic [bmsa_pkg::BATCH_W-1:0] batch_size_q;
	logic [bmsa_pkg::DIMS_W-1:0]  dims_q;
	logic                         mode_q;
	logic [bmsa_pkg::DIMS_W-1:0]  n_eff;
	logic [bmsa_pkg::BATCH_W-1:0] b_eff;

	// Accumulators
	logic signed [bmsa_pkg::PSUM_W-1:0] ps_q   [bmsa_pkg::DIM_MAX];
	logic [bmsa_pkg::WIDE_W-1:0]        pss_q  [bmsa_pkg::DIM_MAX];
	logic signed [bmsa_pkg::BSUM_W-1:0] bms_q  [bmsa_pkg::DIM_MAX];
	logic [bmsa_pkg::WIDE_W-1:0]        bmss_q [bmsa_pkg::DIM_MAX];
	logic [bmsa_pkg::WIDE_W-1:0]        bvs_q  [bmsa_pkg::DIM_MAX];
	logic [bmsa_pkg::WIDE_W-1:0]        bvss_q [bmsa_pkg::DIM_MAX];
	logic [bmsa_pkg::COUNT_W-1:0]       path_count_q;
	logic [bmsa_pkg::COUNT_W-1:0]       batch_count_q;

	// Sequencer
	bmsa_pkg::state_t state_q, state_d, ret_q, ret_d;
	bmsa_pkg::op_t    op_q;
	logic [bmsa_pkg::OPCNT_W-1:0] op_cnt_q;
	logic div_go, sqrt_go, mul_go;
	logic [bmsa_pkg::WIDE_W-1:0]  div_a;
	logic [bmsa_pkg::COUNT_W-1:0] div_b;
	logic [bmsa_pkg::WIDE_W-1:0]  sq_in;
	logic [bmsa_pkg::VAR_W-1:0]   mul_x;

	// Item registers and working values
	logic [bmsa_pkg::DIM_W-1:0]            dim_q, cd_q;
	logic signed [bmsa_pkg::SAMPLE_BITS-1:0] x_q;
	logic [bmsa_pkg::COUNT_W-1:0]          cnt_q;
	logic                                  neg_q;
	logic signed [bmsa_pkg::MEAN_W-1:0]    mean_q;
	logic [bmsa_pkg::WIDE_W-1:0]           m2_q, a_q;
	logic [bmsa_pkg::STDERR_W-1:0]         mstd_q;
	logic [bmsa_pkg::VAR_W-1:0]            mvar_q, vstd_q, v_q;
	bmsa_pkg::rpt_status_t                 status_q;

	// Shared units
	logic [bmsa_pkg::WIDE_W-1:0]  div_n_q;
	logic [bmsa_pkg::COUNT_W-1:0] div_r_q, div_d_q;
	logic [bmsa_pkg::WIDE_W-1:0]  sq_x_q, sq_r_q, sq_bit_q;
	logic [bmsa_pkg::VAR_W-1:0]   mul_a_q, mul_b_q;
	logic [2*bmsa_pkg::VAR_W-1:0] mul_p_q;

	// Output register
	logic                                res_valid_q;
	logic signed [bmsa_pkg::MEAN_W-1:0]  res_mean_q;
	logic [bmsa_pkg::STDERR_W-1:0]       res_mstd_q;
	logic [bmsa_pkg::VAR_W-1:0]          res_mvar_q, res_vstd_q;
	logic [bmsa_pkg::COUNT_W-1:0]        res_cnt_q;
	logic [1:0]                          res_status_q;
	logic [bmsa_pkg::DIM_W-1:0]          res_dim_q;

	// Combinational helpers
	logic                                in_fire, out_load;
	logic [bmsa_pkg::COUNT_W-1:0]        cnt_c, pc_inc;
	logic                                dim_ok, last_c, close_c, cd_last;
	logic [bmsa_pkg::SAMPLE_BITS-1:0]    ax_c;
	logic [bmsa_pkg::PSUM_W-1:0]         ps_mag_in, ps_mag_cd;
	logic [bmsa_pkg::BSUM_W-1:0]         bms_mag_in;
	logic [bmsa_pkg::WIDE_W-1:0]         div_rnd, sub_c, amv_c, mshift_c;
	logic [bmsa_pkg::MEAN_W-1:0]         am_c;
	logic signed [bmsa_pkg::MEAN_W-1:0]  mean_c;
	logic [bmsa_pkg::COUNT_W:0]          rem_sh, rem_sub;
	logic                                rem_ge;
	logic [bmsa_pkg::WIDE_W-1:0]         sq_t;
	logic [bmsa_pkg::WIDE_W-1:0]         mul_pp;
	logic [2*bmsa_pkg::VAR_W:0]          mul_rnd;
	logic signed [bmsa_pkg::PSUM_W:0]    ps_new;
	logic signed [bmsa_pkg::BSUM_W:0]    bms_new;

	function automatic logic [bmsa_pkg::WIDE_W-1:0] sat_add(
		input logic [bmsa_pkg::WIDE_W-1:0] a,
		input logic [bmsa_pkg::WIDE_W-1:0] b
	);
		logic [bmsa_pkg::WIDE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[bmsa_pkg::WIDE_W] ? '1 : s[bmsa_pkg::WIDE_W-1:0];
	endfunction

	function automatic logic [bmsa_pkg::VAR_W-1:0] clamp48(
		input logic [bmsa_pkg::WIDE_W-1:0] v
	);
		return (v[bmsa_pkg::WIDE_W-1:bmsa_pkg::VAR_W] != '0) ? '1 : v[bmsa_pkg::VAR_W-1:0];
	endfunction

	assign cfg.ready     = 1'b1;
	assign samples.ready = (state_q == bmsa_pkg::ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;

	// Effective configuration
	always_comb begin
		if (dims_q == '0) n_eff = bmsa_pkg::DIMS_W'(1);
		else if (dims_q > bmsa_pkg::DIMS_W'(bmsa_pkg::DIM_MAX))
			n_eff = bmsa_pkg::DIMS_W'(bmsa_pkg::DIM_MAX);
		else n_eff = dims_q;
		b_eff = (batch_size_q == '0) ? bmsa_pkg::BATCH_W'(1) : batch_size_q;
	end

	// Count, magnitudes and path completion
	assign cnt_c  = (mode_q == bmsa_pkg::MODE_SIMPLE) ? path_count_q : batch_count_q;
	assign dim_ok = {1'b0, samples.dim_index} < n_eff;
	assign ax_c   = samples.sample_value[bmsa_pkg::SAMPLE_BITS-1]
		? bmsa_pkg::SAMPLE_BITS'(-samples.sample_value) : samples.sample_value;
	assign ps_mag_in  = ps_q[samples.dim_index][bmsa_pkg::PSUM_W-1]
		? bmsa_pkg::PSUM_W'(-ps_q[samples.dim_index]) : ps_q[samples.dim_index];
	assign ps_mag_cd  = ps_q[cd_q][bmsa_pkg::PSUM_W-1]
		? bmsa_pkg::PSUM_W'(-ps_q[cd_q]) : ps_q[cd_q];
	assign bms_mag_in = bms_q[samples.dim_index][bmsa_pkg::BSUM_W-1]
		? bmsa_pkg::BSUM_W'(-bms_q[samples.dim_index]) : bms_q[samples.dim_index];
	assign pc_inc  = (path_count_q == '1) ? path_count_q : path_count_q + 1'b1;
	assign last_c  = ({1'b0, dim_q} == n_eff - 1'b1);
	assign close_c = last_c && (mode_q == bmsa_pkg::MODE_BATCH)
		&& (pc_inc >= {{(bmsa_pkg::COUNT_W-bmsa_pkg::BATCH_W){1'b0}}, b_eff});
	assign cd_last = ({1'b0, cd_q} == n_eff - 1'b1);

	// Rounded quotient and clamped signed mean
	assign div_rnd = div_n_q + {{(bmsa_pkg::WIDE_W-1){1'b0}},
		({div_r_q, 1'b0} >= {1'b0, div_d_q})};
	always_comb begin
		if (neg_q)
			am_c = (div_rnd > 64'h8000_0000) ? 32'h8000_0000 : div_rnd[bmsa_pkg::MEAN_W-1:0];
		else
			am_c = (div_rnd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_rnd[bmsa_pkg::MEAN_W-1:0];
		mean_c = neg_q ? -$signed(am_c) : $signed(am_c);
	end
	assign sub_c = (div_rnd > m2_q) ? div_rnd - m2_q : '0;
	assign amv_c = (a_q > m2_q) ? a_q - m2_q : '0;

	// Rounded product over 2^24, saturated to 64 bits
	assign mul_rnd  = {1'b0, mul_p_q} + (97'd1 << 23);
	assign mshift_c = (mul_rnd[2*bmsa_pkg::VAR_W:88] != '0) ? '1 : mul_rnd[87:24];

	// Step logic of the shared units
	assign rem_sh  = {div_r_q, div_n_q[bmsa_pkg::WIDE_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, div_d_q};
	assign rem_sub = rem_sh - {1'b0, div_d_q};
	assign sq_t    = sq_r_q + sq_bit_q;
	assign mul_pp  = mul_a_q * mul_b_q[bmsa_pkg::VAR_W-1:32];

	// Saturating accumulator updates
	assign ps_new  = ps_q[dim_q] + x_q;
	assign bms_new = bms_q[cd_q] + mean_q;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmsa_pkg::ST_IDLE;
			ret_q   <= bmsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// Next state and unit launches
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		div_go  = 1'b0;
		sqrt_go = 1'b0;
		mul_go  = 1'b0;
		div_a   = '0;
		div_b   = cnt_q;
		sq_in   = div_rnd;
		mul_x   = '0;
		out_load = 1'b0;
		case (state_q)
			bmsa_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (samples.kind == bmsa_pkg::KIND_SAMPLE) begin
						if (dim_ok) begin
							mul_go  = 1'b1;
							mul_x   = bmsa_pkg::VAR_W'(ax_c);
							state_d = bmsa_pkg::ST_WAIT;
							ret_d   = bmsa_pkg::ST_SAMP_UPD;
						end
					end else if (cnt_c == '0 || !dim_ok) begin
						state_d = bmsa_pkg::ST_REP_OUT;
					end else begin
						div_go  = 1'b1;
						div_b   = cnt_c;
						state_d = bmsa_pkg::ST_WAIT;
						if (mode_q == bmsa_pkg::MODE_BATCH) begin
							div_a = bmsa_pkg::WIDE_W'(bms_mag_in);
							ret_d = bmsa_pkg::ST_RB_MEAN;
						end else begin
							div_a = bmsa_pkg::WIDE_W'(ps_mag_in);
							ret_d = bmsa_pkg::ST_RS_MEAN;
						end
					end
				end
			end
			bmsa_pkg::ST_WAIT: begin
				if (op_cnt_q == '0) state_d = ret_q;
			end
			bmsa_pkg::ST_SAMP_UPD: begin
				state_d = close_c ? bmsa_pkg::ST_CB_DIVM : bmsa_pkg::ST_IDLE;
			end
			bmsa_pkg::ST_CB_DIVM: begin
				div_go  = 1'b1;
				div_a   = bmsa_pkg::WIDE_W'(ps_mag_cd);
				div_b   = bmsa_pkg::COUNT_W'(b_eff);
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_CB_MEAN;
			end
			bmsa_pkg::ST_CB_MEAN: begin
				mul_go  = 1'b1;
				mul_x   = bmsa_pkg::VAR_W'(am_c);
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_CB_DIVQ;
			end
			bmsa_pkg::ST_CB_DIVQ: begin
				div_go  = 1'b1;
				div_a   = pss_q[cd_q];
				div_b   = bmsa_pkg::COUNT_W'(b_eff);
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_CB_VAR;
			end
			bmsa_pkg::ST_CB_VAR: begin
				mul_go  = 1'b1;
				mul_x   = clamp48(sub_c);
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_CB_FOLD;
			end
			bmsa_pkg::ST_CB_FOLD: begin
				state_d = cd_last ? bmsa_pkg::ST_IDLE : bmsa_pkg::ST_CB_DIVM;
			end
			bmsa_pkg::ST_RB_MEAN, bmsa_pkg::ST_RS_MEAN: begin
				mul_go  = 1'b1;
				mul_x   = bmsa_pkg::VAR_W'(am_c);
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = (state_q == bmsa_pkg::ST_RB_MEAN)
					? bmsa_pkg::ST_RB_DIVA : bmsa_pkg::ST_RS_DIVA;
			end
			bmsa_pkg::ST_RB_DIVA: begin
				div_go  = 1'b1;
				div_a   = bmss_q[dim_q];
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RB_DIVV;
			end
			bmsa_pkg::ST_RB_DIVV: begin
				div_go  = 1'b1;
				div_a   = bvs_q[dim_q];
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RB_MV;
			end
			bmsa_pkg::ST_RB_MV: begin
				if (cnt_q < bmsa_pkg::COUNT_W'(2)) begin
					state_d = bmsa_pkg::ST_REP_OUT;
				end else begin
					div_go  = 1'b1;
					div_a   = amv_c;
					state_d = bmsa_pkg::ST_WAIT;
					ret_d   = bmsa_pkg::ST_RB_SQM;
				end
			end
			bmsa_pkg::ST_RB_SQM: begin
				sqrt_go = 1'b1;
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RB_MUL;
			end
			bmsa_pkg::ST_RB_MUL: begin
				mul_go  = 1'b1;
				mul_x   = mvar_q;
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RB_DIVW;
			end
			bmsa_pkg::ST_RB_DIVW: begin
				div_go  = 1'b1;
				div_a   = bvss_q[dim_q];
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RB_DIVX;
			end
			bmsa_pkg::ST_RB_DIVX: begin
				div_go  = 1'b1;
				div_a   = sub_c;
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RB_SQV;
			end
			bmsa_pkg::ST_RB_SQV: begin
				sqrt_go = 1'b1;
				sq_in   = (div_rnd[bmsa_pkg::WIDE_W-1:40] != '0)
					? {40'hFF_FFFF_FFFF, 24'd0} : {div_rnd[39:0], 24'd0};
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RB_END;
			end
			bmsa_pkg::ST_RB_END, bmsa_pkg::ST_RS_END: begin
				state_d = bmsa_pkg::ST_REP_OUT;
			end
			bmsa_pkg::ST_RS_DIVA: begin
				div_go  = 1'b1;
				div_a   = pss_q[dim_q];
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RS_S;
			end
			bmsa_pkg::ST_RS_S: begin
				if (cnt_q < bmsa_pkg::COUNT_W'(2)) begin
					state_d = bmsa_pkg::ST_REP_OUT;
				end else begin
					div_go  = 1'b1;
					div_a   = sub_c;
					div_b   = cnt_q - 1'b1;
					state_d = bmsa_pkg::ST_WAIT;
					ret_d   = bmsa_pkg::ST_RS_SQ;
				end
			end
			bmsa_pkg::ST_RS_SQ: begin
				sqrt_go = 1'b1;
				state_d = bmsa_pkg::ST_WAIT;
				ret_d   = bmsa_pkg::ST_RS_END;
			end
			bmsa_pkg::ST_REP_OUT: begin
				if (!res_valid_q || reports.ready) begin
					out_load = 1'b1;
					state_d  = bmsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmsa_pkg::ST_IDLE;
			end
		endcase
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_size_q <= bmsa_pkg::BATCH_SIZE_RST;
			dims_q       <= bmsa_pkg::DIMS_RST;
			mode_q       <= bmsa_pkg::MODE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				bmsa_pkg::CFG_BATCH_SIZE:  batch_size_q <= cfg.data[bmsa_pkg::BATCH_W-1:0];
				bmsa_pkg::CFG_DIMS_IN_USE: dims_q <= cfg.data[bmsa_pkg::DIMS_W-1:0];
				bmsa_pkg::CFG_STAT_MODE:   mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Advance the shared unit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= bmsa_pkg::OP_DIV;
			op_cnt_q <= '0;
		end else if (div_go) begin
			op_q     <= bmsa_pkg::OP_DIV;
			op_cnt_q <= bmsa_pkg::OPCNT_W'(bmsa_pkg::DIV_STEPS - 1);
		end else if (sqrt_go) begin
			op_q     <= bmsa_pkg::OP_SQRT;
			op_cnt_q <= bmsa_pkg::OPCNT_W'(bmsa_pkg::SQRT_STEPS - 1);
		end else if (mul_go) begin
			op_q     <= bmsa_pkg::OP_MUL;
			op_cnt_q <= bmsa_pkg::OPCNT_W'(bmsa_pkg::MUL_STEPS - 1);
		end else if (state_q == bmsa_pkg::ST_WAIT && op_cnt_q != '0) begin
			op_cnt_q <= op_cnt_q - 1'b1;
		end
	end

	// Shared divider, square root and multiplier: one step per cycle
	always_ff @(posedge clk) begin
		if (div_go) begin
			div_n_q <= div_a;
			div_r_q <= '0;
			div_d_q <= div_b;
		end else if (state_q == bmsa_pkg::ST_WAIT && op_q == bmsa_pkg::OP_DIV) begin
			div_n_q <= {div_n_q[bmsa_pkg::WIDE_W-2:0], rem_ge};
			div_r_q <= rem_ge ? rem_sub[bmsa_pkg::COUNT_W-1:0] : rem_sh[bmsa_pkg::COUNT_W-1:0];
		end
		if (sqrt_go) begin
			sq_x_q   <= sq_in;
			sq_r_q   <= '0;
			sq_bit_q <= 64'd1 << 62;
		end else if (state_q == bmsa_pkg::ST_WAIT && op_q == bmsa_pkg::OP_SQRT) begin
			if (sq_x_q >= sq_t) begin
				sq_x_q <= sq_x_q - sq_t;
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (mul_go) begin
			mul_a_q <= mul_x;
			mul_b_q <= mul_x;
			mul_p_q <= '0;
		end else if (state_q == bmsa_pkg::ST_WAIT && op_q == bmsa_pkg::OP_MUL) begin
			mul_p_q <= {mul_p_q[2*bmsa_pkg::VAR_W-17:0], 16'd0}
				+ {{(2*bmsa_pkg::VAR_W-bmsa_pkg::WIDE_W){1'b0}}, mul_pp};
			mul_b_q <= {mul_b_q[bmsa_pkg::VAR_W-17:0], 16'd0};
		end
	end

	// Latch the item and the working values of the sequence
	always_ff @(posedge clk) begin
		case (state_q)
			bmsa_pkg::ST_IDLE: begin
				if (in_fire) begin
					dim_q    <= samples.dim_index;
					x_q      <= samples.sample_value;
					cnt_q    <= cnt_c;
					mean_q   <= '0;
					mstd_q   <= '0;
					mvar_q   <= '0;
					vstd_q   <= '0;
					status_q <= (cnt_c == '0 || !dim_ok) ? bmsa_pkg::RPT_NO_DATA
						: bmsa_pkg::RPT_OK;
					neg_q    <= (mode_q == bmsa_pkg::MODE_BATCH)
						? bms_q[samples.dim_index][bmsa_pkg::BSUM_W-1]
						: ps_q[samples.dim_index][bmsa_pkg::PSUM_W-1];
				end
			end
			bmsa_pkg::ST_SAMP_UPD: cd_q <= '0;
			bmsa_pkg::ST_CB_DIVM: neg_q <= ps_q[cd_q][bmsa_pkg::PSUM_W-1];
			bmsa_pkg::ST_CB_MEAN, bmsa_pkg::ST_RB_MEAN, bmsa_pkg::ST_RS_MEAN: mean_q <= mean_c;
			bmsa_pkg::ST_CB_DIVQ, bmsa_pkg::ST_RB_DIVA, bmsa_pkg::ST_RS_DIVA:
				m2_q <= mul_p_q[bmsa_pkg::WIDE_W-1:0];
			bmsa_pkg::ST_CB_VAR: v_q <= clamp48(sub_c);
			bmsa_pkg::ST_CB_FOLD: begin
				if (!cd_last) cd_q <= cd_q + 1'b1;
			end
			bmsa_pkg::ST_RB_DIVV: a_q <= div_rnd;
			bmsa_pkg::ST_RB_MV: begin
				mvar_q <= clamp48(div_rnd);
				if (cnt_q < bmsa_pkg::COUNT_W'(2)) status_q <= bmsa_pkg::RPT_FEW;
			end
			bmsa_pkg::ST_RB_MUL: mstd_q <= sq_r_q[bmsa_pkg::STDERR_W-1:0];
			bmsa_pkg::ST_RB_DIVW: m2_q <= mshift_c;
			bmsa_pkg::ST_RB_END: vstd_q <= bmsa_pkg::VAR_W'(sq_r_q[31:0]);
			bmsa_pkg::ST_RS_S: begin
				if (cnt_q < bmsa_pkg::COUNT_W'(2)) status_q <= bmsa_pkg::RPT_FEW;
			end
			bmsa_pkg::ST_RS_END: mstd_q <= sq_r_q[bmsa_pkg::STDERR_W-1:0];
			default: ;
		endcase
	end

	// Update accumulators and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bmsa_pkg::DIM_MAX; i++) begin
				ps_q[i]   <= '0;
				pss_q[i]  <= '0;
				bms_q[i]  <= '0;
				bmss_q[i] <= '0;
				bvs_q[i]  <= '0;
				bvss_q[i] <= '0;
			end
			path_count_q  <= '0;
			batch_count_q <= '0;
		end else begin
			case (state_q)
				bmsa_pkg::ST_SAMP_UPD: begin
					if (ps_new[bmsa_pkg::PSUM_W] != ps_new[bmsa_pkg::PSUM_W-1])
						ps_q[dim_q] <= ps_new[bmsa_pkg::PSUM_W]
							? {1'b1, {(bmsa_pkg::PSUM_W-1){1'b0}}}
							: {1'b0, {(bmsa_pkg::PSUM_W-1){1'b1}}};
					else
						ps_q[dim_q] <= ps_new[bmsa_pkg::PSUM_W-1:0];
					pss_q[dim_q] <= sat_add(pss_q[dim_q], mul_p_q[bmsa_pkg::WIDE_W-1:0]);
					if (last_c) path_count_q <= pc_inc;
				end
				bmsa_pkg::ST_CB_FOLD: begin
					if (bms_new[bmsa_pkg::BSUM_W] != bms_new[bmsa_pkg::BSUM_W-1])
						bms_q[cd_q] <= bms_new[bmsa_pkg::BSUM_W]
							? {1'b1, {(bmsa_pkg::BSUM_W-1){1'b0}}}
							: {1'b0, {(bmsa_pkg::BSUM_W-1){1'b1}}};
					else
						bms_q[cd_q] <= bms_new[bmsa_pkg::BSUM_W-1:0];
					bmss_q[cd_q] <= sat_add(bmss_q[cd_q], m2_q);
					bvs_q[cd_q]  <= sat_add(bvs_q[cd_q], bmsa_pkg::WIDE_W'(v_q));
					bvss_q[cd_q] <= sat_add(bvss_q[cd_q], mshift_c);
					// Last dimension folded: drop the batch
					if (cd_last) begin
						for (int i = 0; i < bmsa_pkg::DIM_MAX; i++) begin
							ps_q[i]  <= '0;
							pss_q[i] <= '0;
						end
						path_count_q <= '0;
						if (batch_count_q != '1) batch_count_q <= batch_count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the finished item until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (reports.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_mean_q   <= mean_q;
			res_mstd_q   <= mstd_q;
			res_mvar_q   <= mvar_q;
			res_vstd_q   <= vstd_q;
			res_cnt_q    <= cnt_q;
			res_status_q <= status_q;
			res_dim_q    <= dim_q;
		end
	end

	assign reports.valid           = res_valid_q;
	assign reports.mean_value      = res_mean_q;
	assign reports.mean_stderr     = res_mstd_q;
	assign reports.mean_variance   = res_mvar_q;
	assign reports.variance_stderr = res_vstd_q;
	assign reports.sample_count    = res_cnt_q;
	assign reports.report_status   = res_status_q;
	assign reports.report_dim      = res_dim_q;

	// Divider remainder always stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmsa_pkg::ST_WAIT && op_q == bmsa_pkg::OP_DIV) |-> div_r_q < div_d_q)
		else $error("divider remainder not below divisor");

	// Multiplier runs no more than its digit count
	a_mul_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmsa_pkg::ST_WAIT && op_q == bmsa_pkg::OP_MUL)
		|-> op_cnt_q < bmsa_pkg::OPCNT_W'(bmsa_pkg::MUL_STEPS))
		else $error("multiplier step count out of range");

	// Folding the last dimension closes the batch
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmsa_pkg::ST_CB_FOLD && cd_last)
		|=> (path_count_q == '0 && state_q == bmsa_pkg::ST_IDLE))
		else $error("batch closure did not clear the path count");

	// A report request always leaves idle to produce an item
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && samples.kind == bmsa_pkg::KIND_REPORT) |=> state_q != bmsa_pkg::ST_IDLE)
		else $error("report request produced no work");

endmodule
`default_nettype wire

// File: sim/batch_means_statistics_accumulator_unit_tb.sv
`timescale 1ns / 1ps
module batch_means_statistics_accumulator_unit_tb;
	import bmsa_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int SETTLE_CYCLES = 2600;

	typedef struct {
		logic [MEAN_W-1:0]   mean_value;
		logic [STDERR_W-1:0] mean_stderr;
		logic [VAR_W-1:0]    mean_variance;
		logic [VAR_W-1:0]    variance_stderr;
		logic [COUNT_W-1:0]  sample_count;
		logic [1:0]          report_status;
		logic [DIM_W-1:0]    report_dim;
	} report_t;

	logic clk;
	logic arst_n;
	bmsa_cfg_if cfg_bus();
	bmsa_in_if in_bus();
	bmsa_out_if out_bus();

	batch_means_statistics_accumulator_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_bus), .samples(in_bus), .reports(out_bus)
	);

	// Predicted accumulator state and registers
	longint          acc_sum [DIM_MAX];
	longint unsigned acc_sq [DIM_MAX];
	longint          bm_sum [DIM_MAX];
	longint unsigned bm_sq [DIM_MAX];
	longint unsigned bv_sum [DIM_MAX];
	longint unsigned bv_sq [DIM_MAX];
	longint unsigned paths_done;
	longint unsigned batches_done;
	int unsigned     cur_batch_size;
	int unsigned     cur_dims;
	logic            cur_mode;

	report_t pending_reports[$];
	int      fail_count;
	int      cycle_count;
	int      send_idle_pct;
	int      recv_stall_pct;
	int      hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint unsigned div_round(longint unsigned a, longint unsigned d);
		longint unsigned q, r;
		q = a / d;
		r = a % d;
		if (r >= d - r) q++;
		return q;
	endfunction

	function automatic longint sdiv_round(longint a, longint unsigned d);
		longint unsigned mag;
		longint q;
		mag = (a < 0) ? longint'(-a) : longint'(a);
		q = longint'(div_round(mag, d));
		if (a < 0) q = -q;
		return clamp(q, -64'sd2147483648, 64'sd2147483647);
	endfunction

	// Round(a*b / 2^24), saturated at 64 bits
	function automatic longint unsigned square_q24(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b} + (128'd1 << 23);
		if (p[127:88] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
		return p[87:24];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic int unsigned dims_active();
		int unsigned d;
		d = (cur_dims == 0) ? 1 : cur_dims;
		return (d > DIM_MAX) ? DIM_MAX : d;
	endfunction

	// Fold the finished batch into the cross-batch sums
	task automatic fold_batch();
		longint unsigned b, am, m2, q, v;
		longint m;
		b = (cur_batch_size == 0) ? 1 : cur_batch_size;
		for (int d = 0; d < dims_active(); d++) begin
			m = sdiv_round(acc_sum[d], b);
			am = (m < 0) ? longint'(-m) : longint'(m);
			m2 = am * am;
			q = div_round(acc_sq[d], b);
			v = (q > m2) ? q - m2 : 0;
			if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
			bm_sum[d] = clamp(bm_sum[d] + m, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
			bm_sq[d] = sat_add(bm_sq[d], m2);
			bv_sum[d] = sat_add(bv_sum[d], v);
			bv_sq[d] = sat_add(bv_sq[d], square_q24(v, v));
		end
		for (int d = 0; d < DIM_MAX; d++) begin
			acc_sum[d] = 0;
			acc_sq[d] = 0;
		end
		paths_done = 0;
		if (batches_done != 32'hFFFF_FFFF) batches_done++;
	endtask

	// Advance the predicted state by one accepted item
	task automatic predict_item(logic kind, logic [DIM_W-1:0] dim, logic signed [15:0] val);
		int unsigned n, d;
		longint x, mean;
		longint unsigned ax, am, a, s, mv, mv2, vv, cnt, b;
		report_t r;
		n = dims_active();
		d = dim;
		if (kind == KIND_SAMPLE) begin
			if (d >= n) return;
			x = val;
			ax = (x < 0) ? longint'(-x) : longint'(x);
			acc_sum[d] = clamp(acc_sum[d] + x, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
			acc_sq[d] = sat_add(acc_sq[d], ax * ax);
			if (d == n - 1) begin
				if (paths_done != 32'hFFFF_FFFF) paths_done++;
				b = (cur_batch_size == 0) ? 1 : cur_batch_size;
				if (cur_mode == MODE_BATCH && paths_done >= b) fold_batch();
			end
			return;
		end
		mean = 0;
		r.mean_stderr = 0;
		r.mean_variance = 0;
		r.variance_stderr = 0;
		r.report_status = RPT_OK;
		cnt = (cur_mode == MODE_BATCH) ? batches_done : paths_done;
		if (cnt == 0 || d >= n) begin
			r.report_status = RPT_NO_DATA;
		end else if (cur_mode == MODE_BATCH) begin
			mean = sdiv_round(bm_sum[d], cnt);
			am = (mean < 0) ? longint'(-mean) : longint'(mean);
			a = div_round(bm_sq[d], cnt);
			mv = div_round(bv_sum[d], cnt);
			if (mv > 64'hFFFF_FFFF_FFFF) mv = 64'hFFFF_FFFF_FFFF;
			r.mean_variance = mv;
			if (cnt < 2) begin
				r.report_status = RPT_FEW;
			end else begin
				s = (a > am * am) ? a - am * am : 0;
				r.mean_stderr = int_sqrt(div_round(s, cnt));
				mv2 = square_q24(mv, mv);
				vv = div_round(bv_sq[d], cnt);
				vv = (vv > mv2) ? vv - mv2 : 0;
				vv = div_round(vv, cnt);
				if (vv > 64'hFF_FFFF_FFFF) vv = 64'hFF_FFFF_FFFF;
				r.variance_stderr = int_sqrt(vv << 24);
			end
		end else begin
			mean = sdiv_round(acc_sum[d], cnt);
			am = (mean < 0) ? longint'(-mean) : longint'(mean);
			a = div_round(acc_sq[d], cnt);
			s = (a > am * am) ? a - am * am : 0;
			if (cnt < 2) r.report_status = RPT_FEW;
			else r.mean_stderr = int_sqrt(div_round(s, cnt - 1));
		end
		r.mean_value = mean[31:0];
		r.sample_count = cnt[31:0];
		r.report_dim = dim;
		pending_reports.push_back(r);
	endtask

	// Offer one item, hold it until taken, then idle at random
	task automatic send_item(logic kind, logic [DIM_W-1:0] dim, logic [15:0] val);
		int gap;
		in_bus.valid = 1'b1;
		in_bus.kind = kind;
		in_bus.dim_index = dim;
		in_bus.sample_value = val;
		do @(posedge clk); while (!in_bus.ready);
		predict_item(kind, dim, val);
		@(negedge clk);
		in_bus.valid = 1'b0;
		in_bus.kind = $urandom_range(0, 1);
		in_bus.sample_value = $urandom;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_sample(int dim, int val);
		send_item(KIND_SAMPLE, dim[DIM_W-1:0], val[15:0]);
	endtask

	task automatic send_report(int dim);
		send_item(KIND_REPORT, dim[DIM_W-1:0], $urandom);
	endtask

	// Wait for the block to fall idle
	task automatic drain();
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned value);
		drain();
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data = value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			CFG_BATCH_SIZE:  cur_batch_size = value & 16'hFFFF;
			CFG_DIMS_IN_USE: cur_dims = value & 5'h1F;
			CFG_STAT_MODE:   cur_mode = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic setup(int unsigned bsize, int unsigned dims, logic mode);
		write_reg(CFG_BATCH_SIZE, bsize);
		write_reg(CFG_DIMS_IN_USE, dims);
		write_reg(CFG_STAT_MODE, mode);
	endtask

	// One whole path with random content and stray samples, optionally a report after it
	task automatic send_path(int unsigned n);
		for (int d = 0; d < n; d++) begin
			if ($urandom_range(0, 9) == 0) send_sample($urandom_range(0, 15), $urandom);
			send_sample(d, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8191) - 4096);
		end
		if ($urandom_range(0, 2) == 0) send_report($urandom_range(0, n));
	endtask

	// Receiver: stall at random and for requested hold-offs
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_bus.ready = 1'b0;
		end else begin
			out_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Compare each taken report with the oldest prediction
	always @(posedge clk) begin
		report_t e;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (pending_reports.size() == 0) begin
				$error("report with none pending, dim %0d", out_bus.report_dim);
				fail_count++;
			end else begin
				e = pending_reports.pop_front();
				if (out_bus.mean_value !== e.mean_value) begin
					$error("mean_value exp %h got %h", e.mean_value, out_bus.mean_value);
					fail_count++;
				end
				if (out_bus.mean_stderr !== e.mean_stderr) begin
					$error("mean_stderr exp %h got %h", e.mean_stderr, out_bus.mean_stderr);
					fail_count++;
				end
				if (out_bus.mean_variance !== e.mean_variance) begin
					$error("mean_variance exp %h got %h", e.mean_variance, out_bus.mean_variance);
					fail_count++;
				end
				if (out_bus.variance_stderr !== e.variance_stderr) begin
					$error("variance_stderr exp %h got %h", e.variance_stderr,
						out_bus.variance_stderr);
					fail_count++;
				end
				if (out_bus.sample_count !== e.sample_count) begin
					$error("sample_count exp %h got %h", e.sample_count, out_bus.sample_count);
					fail_count++;
				end
				if (out_bus.report_status !== e.report_status) begin
					$error("report_status exp %h got %h", e.report_status, out_bus.report_status);
					fail_count++;
				end
				if (out_bus.report_dim !== e.report_dim) begin
					$error("report_dim exp %h got %h", e.report_dim, out_bus.report_dim);
					fail_count++;
				end
			end
		end
	end

	task automatic test_directed();
		send_report(0);
		setup(2, 2, MODE_BATCH);
		send_sample(0, -32768);
		send_sample(1, 32767);
		send_sample(0, 32767);
		send_sample(0, 0);
		send_sample(1, -32768);
		send_report(1);
		send_sample(5, 1234);
		send_sample(0, -1);
		send_sample(1, 1);
		send_sample(0, 4096);
		send_sample(1, -4096);
		send_report(0);
		send_report(1);
		send_report(2);
		send_report(15);
		write_reg(CFG_STAT_MODE, MODE_SIMPLE);
		send_sample(0, 100);
		send_sample(1, -100);
		send_report(0);
		send_sample(0, 300);
		send_sample(1, 200);
		send_report(1);
		setup(0, 0, MODE_BATCH);
		send_sample(0, 777);
		send_sample(0, -777);
		send_report(0);
		send_report(1);
	endtask

	task automatic test_wide_config();
		setup(65535, 31, MODE_SIMPLE);
		for (int p = 0; p < 3; p++) send_path(DIM_MAX);
		send_report(15);
		write_reg(CFG_STAT_MODE, MODE_BATCH);
		send_path(DIM_MAX);
		send_report(3);
		setup(1, 16, MODE_BATCH);
		for (int p = 0; p < 3; p++) send_path(DIM_MAX);
		send_report(15);
		write_reg(CFG_DIMS_IN_USE, 3);
		send_path(3);
		send_report(2);
	endtask

	task automatic test_random_phase(int sidle, int rstall, int items);
		int unsigned n;
		int sent;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		setup($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 4),
			$urandom_range(0, 4) == 0 ? $urandom_range(5, 20) : $urandom_range(1, 4),
			$urandom_range(0, 1));
		n = dims_active();
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1)) send_report($urandom_range(0, 15));
				else send_sample($urandom_range(0, 15), $urandom);
				sent++;
			end else begin
				send_path(n);
				sent += n + 1;
			end
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		setup(1, 2, MODE_BATCH);
		send_path(2);
		send_path(2);
		@(posedge clk);
		hold_left = 3000;
		for (int i = 0; i < 6; i++) begin
			send_report(i % 3);
			send_path(2);
		end
	endtask

	task automatic test_sender_pause();
		send_path(dims_active());
		send_report(0);
		while (pending_reports.size() != 0) @(negedge clk);
		send_report(1);
		send_path(dims_active());
	endtask

	initial begin
		cycle_count = 0;
		fail_count = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_BATCH_SIZE;
		cfg_bus.data = '0;
		in_bus.valid = 1'b0;
		in_bus.kind = KIND_SAMPLE;
		in_bus.dim_index = '0;
		in_bus.sample_value = '0;
		out_bus.ready = 1'b0;
		for (int d = 0; d < DIM_MAX; d++) begin
			acc_sum[d] = 0;
			acc_sq[d] = 0;
			bm_sum[d] = 0;
			bm_sq[d] = 0;
			bv_sum[d] = 0;
			bv_sq[d] = 0;
		end
		paths_done = 0;
		batches_done = 0;
		cur_batch_size = BATCH_SIZE_RST;
		cur_dims = DIMS_RST;
		cur_mode = MODE_RST;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_directed();
		test_wide_config();
		for (int i = 0; i < 4; i++) begin
			test_random_phase(0, 0, 75);
			test_random_phase(53, 0, 75);
			test_random_phase(0, 53, 75);
			test_random_phase(7, 7, 75);
		end
		test_backpressure();
		test_sender_pause();

		drain();
		if (fail_count == 0 && pending_reports.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/bmsa_pkg.sv
rtl/core/bmsa_cfg_if.sv
rtl/core/bmsa_in_if.sv
rtl/core/bmsa_out_if.sv
rtl/core/batch_means_statistics_accumulator_unit.sv
sim/batch_means_statistics_accumulator_unit_tb.sv
